[src/boid_pkg.sv]
// Shared types and constants for the BER object identifier element decoder.
`default_nettype none

package boid_pkg;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_LEN,
    PH_LENMORE,
    PH_FIRST,
    PH_ARCS
  } phase_t;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TAG       = 3'd1;
  localparam logic [2:0] ERR_SHORT     = 3'd2;
  localparam logic [2:0] ERR_ZERO_LEN  = 3'd3;
  localparam logic [2:0] ERR_ARC_OVER  = 3'd4;
  localparam logic [2:0] ERR_LEN_LONG  = 3'd5;

  localparam logic [7:0] TAG_RESET = 8'd6;
  localparam logic [0:0] REG_EXPECTED_TAG = 1'b0;

  // Quotient by 40 of a byte is (b * 205) >> 13, exact for 0..255.
  localparam logic [15:0] DIV40_MUL = 16'd205;
  localparam logic [7:0]  ARC_BASE  = 8'd40;

  localparam int RES_DEPTH = 4;

  typedef struct packed {
    logic [31:0] arc_value;
    logic        arc_valid;
    logic        element_done;
    logic [2:0]  error_code;
    logic        run_last;
  } result_t;

endpackage

`default_nettype wire

[src/ber_oid_element_decoder.sv]
// Top level of the BER object identifier element decoder.
//
// Decodes a BER object identifier element fed one byte per item: tag check
// against expected_tag, short or long form length, then arcs (the first
// content byte gives byte/40 and byte%40, later arcs are base-128). Each
// byte is held in an input register and is decoded in a single pass
// into a four-entry result queue, so a byte is taken every cycle while the
// queue has room for two results. The output side hands out one result per
// cycle while out_stall is low. A byte is registered, decoded and written
// into the queue, whose head drives the outputs. Errors give one result
// with the error code; after an error that is not on a buffer_end byte,
// bytes are dropped up to the next buffer_end.
`default_nettype none

module ber_oid_element_decoder
  import boid_pkg::*;
#(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  byte_in,
  input  wire logic        buffer_end,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      arc_value,
  output logic             arc_valid,
  output logic             element_done,
  output logic [2:0]       error_code,
  output logic             run_last,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CW = $clog2(RES_DEPTH+1);

  // configuration
  logic [7:0] expected_tag;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EXPECTED_TAG) ? {24'd0, expected_tag} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_tag <= TAG_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_EXPECTED_TAG) begin
      expected_tag <= pwdata[7:0];
    end
  end

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_end;
  logic       go;
  logic [CW-1:0] q_count;

  assign go       = s1_valid && (q_count <= CW'(RES_DEPTH-2));
  assign in_stall = s1_valid && !go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= byte_in;
      s1_end  <= buffer_end;
    end
  end

  // decoder state
  phase_t      phase, phase_next;
  logic [2:0]  length_bytes_left, length_bytes_left_next;
  logic [31:0] content_left, content_left_next;
  logic [31:0] arc_accumulator, arc_accumulator_next;
  logic        error_latched, error_latched_next;

  logic [15:0] div_prod;
  logic [2:0]  quot;
  logic [7:0]  rem;
  logic [31:0] cont_dec;
  logic [31:0] cont_shift;
  logic [31:0] acc_shift;
  logic [2:0]  err;
  logic        finished;
  logic [31:0] arc0, arc1;
  logic [1:0]  narcs;
  logic        push0, push1;
  result_t     res0, res1;

  assign div_prod   = 16'(s1_byte) * DIV40_MUL;
  assign quot       = div_prod[15:13];
  assign rem        = s1_byte - 8'(quot) * ARC_BASE;
  assign cont_dec   = content_left - 32'd1;
  assign cont_shift = {content_left[23:0], s1_byte};
  assign acc_shift  = {arc_accumulator[24:0], s1_byte[6:0]};

  always_comb begin
    phase_next             = phase;
    length_bytes_left_next = length_bytes_left;
    content_left_next      = content_left;
    arc_accumulator_next   = arc_accumulator;
    error_latched_next     = error_latched;
    err                    = ERR_NONE;
    finished               = 1'b0;
    arc0                   = 32'd0;
    arc1                   = 32'd0;
    narcs                  = 2'd0;
    push0                  = 1'b0;
    push1                  = 1'b0;
    res0                   = '0;
    res1                   = '0;

    if (go) begin
      if (error_latched) begin
        if (s1_end) begin
          error_latched_next     = 1'b0;
          phase_next             = PH_TAG;
          length_bytes_left_next = 3'd0;
          content_left_next      = 32'd0;
          arc_accumulator_next   = 32'd0;
        end
      end else begin
        unique case (phase)
          PH_TAG: begin
            if (s1_byte != expected_tag) begin
              err = ERR_TAG;
            end else begin
              phase_next = PH_LEN;
            end
          end
          PH_LEN: begin
            if (s1_byte[7]) begin
              if (int'(s1_byte[6:0]) > MAX_LENGTH_BYTES) begin
                err = ERR_LEN_LONG;
              end else begin
                length_bytes_left_next = (s1_byte[6:0] == 7'd0) ? 3'd1 : s1_byte[2:0];
                content_left_next      = 32'd0;
                phase_next             = PH_LENMORE;
              end
            end else begin
              content_left_next = 32'(s1_byte);
              if (s1_byte == 8'd0) begin
                err = ERR_ZERO_LEN;
              end else begin
                phase_next = PH_FIRST;
              end
            end
          end
          PH_LENMORE: begin
            content_left_next      = cont_shift;
            length_bytes_left_next = length_bytes_left - 3'd1;
            if (length_bytes_left == 3'd1) begin
              if (cont_shift == 32'd0) begin
                err = ERR_ZERO_LEN;
              end else begin
                phase_next = PH_FIRST;
              end
            end
          end
          PH_FIRST: begin
            content_left_next    = cont_dec;
            arc0                 = 32'(quot);
            arc1                 = 32'(rem);
            narcs                = 2'd2;
            arc_accumulator_next = 32'd0;
            phase_next           = PH_ARCS;
            finished             = (cont_dec == 32'd0);
          end
          PH_ARCS: begin
            if (content_left != 32'd0) begin
              content_left_next = cont_dec;
            end
            arc_accumulator_next = acc_shift;
            if (s1_byte[7]) begin
              if (content_left <= 32'd1) begin
                err = ERR_ARC_OVER;
              end
            end else begin
              arc0                 = acc_shift;
              narcs                = 2'd1;
              arc_accumulator_next = 32'd0;
              finished             = (content_left <= 32'd1);
            end
          end
          default: begin
            phase_next             = PH_TAG;
            length_bytes_left_next = 3'd0;
            content_left_next      = 32'd0;
            arc_accumulator_next   = 32'd0;
          end
        endcase

        if (err == ERR_NONE && s1_end && !finished) begin
          err = ERR_SHORT;
        end

        if (err != ERR_NONE || finished) begin
          phase_next             = PH_TAG;
          length_bytes_left_next = 3'd0;
          content_left_next      = 32'd0;
          arc_accumulator_next   = 32'd0;
        end

        if (err != ERR_NONE) begin
          error_latched_next = !s1_end;
          push0              = 1'b1;
          res0.error_code    = err;
          res0.run_last      = 1'b1;
        end else if (narcs != 2'd0) begin
          // The last arc of the byte carries run_last, and done if it ends the element.
          push0             = 1'b1;
          push1             = (narcs == 2'd2);
          res0.arc_value    = arc0;
          res0.arc_valid    = 1'b1;
          res0.run_last     = (narcs == 2'd1);
          res0.element_done = finished && (narcs == 2'd1);
          res1.arc_value    = arc1;
          res1.arc_valid    = 1'b1;
          res1.run_last     = 1'b1;
          res1.element_done = finished;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_TAG;
      length_bytes_left <= 3'd0;
      content_left      <= 32'd0;
      arc_accumulator   <= 32'd0;
      error_latched     <= 1'b0;
    end else begin
      phase             <= phase_next;
      length_bytes_left <= length_bytes_left_next;
      content_left      <= content_left_next;
      arc_accumulator   <= arc_accumulator_next;
      error_latched     <= error_latched_next;
    end
  end

  // result queue
  result_t q_head;

  boid_rfifo #(
    .DEPTH (RES_DEPTH)
  ) u_rfifo (
    .clk   (clk),
    .rst   (rst),
    .push0 (push0),
    .push1 (push1),
    .data0 (res0),
    .data1 (res1),
    .pop   (!out_stall),
    .head  (q_head),
    .count (q_count)
  );

  assign out_valid    = (q_count != '0);
  assign arc_value    = q_head.arc_value;
  assign arc_valid    = q_head.arc_valid;
  assign element_done = q_head.element_done;
  assign error_code   = q_head.error_code;
  assign run_last     = q_head.run_last;

endmodule

`default_nettype wire

[src/boid_rfifo.sv]
// Result queue: takes up to two results a cycle and hands out one while pop is high.
`default_nettype none

module boid_rfifo
  import boid_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push0,
  input  wire logic                       push1,
  input  wire result_t                    data0,
  input  wire result_t                    data1,
  input  wire logic                       pop,
  output result_t                         head,
  output logic [$clog2(DEPTH+1)-1:0]      count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  result_t         entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW-1:0]   wr_ptr1;
  logic [CW-1:0]   n_push;
  logic            do_pop;

  assign do_pop  = pop && (count != '0);
  assign wr_ptr1 = (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + PW'(1);
  assign n_push  = CW'(push0) + CW'(push0 && push1);
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push0) begin
      entries[wr_ptr] <= data0;
    end
    if (push0 && push1) begin
      entries[wr_ptr1] <= data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push0 && push1) begin
        wr_ptr <= (wr_ptr1 == PW'(DEPTH-1)) ? '0 : wr_ptr1 + PW'(1);
      end else if (push0) begin
        wr_ptr <= wr_ptr1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + n_push - CW'(do_pop);
    end
  end

endmodule

`default_nettype wire
